// ===== rtl/ofmt_pkg.sv =====
// shared types, character codes and divider constants for the order message formatter
package ofmt_pkg;

  // widest decimal form of a 32-bit magnitude
  parameter int unsigned DIGIT_MAX = 10;
  parameter int unsigned DIGIT_IDX_W = $clog2(DIGIT_MAX);
  parameter int unsigned DIGIT_CNT_W = $clog2(DIGIT_MAX + 1);

  parameter int unsigned HEAD_LEN = 4;
  parameter int unsigned HEAD_IDX_W = $clog2(HEAD_LEN);

  parameter logic [7:0] CH_ZERO  = 8'h30;
  parameter logic [7:0] CH_SPACE = 8'h20;
  parameter logic [7:0] CH_MINUS = 8'h2D;
  parameter logic [7:0] CH_NUL   = 8'h00;

  // "NEW "
  parameter logic [7:0] HEAD_TEXT [HEAD_LEN] = '{8'h4E, 8'h45, 8'h57, 8'h20};

  // floor(v / 10) = (v * 0xCCCCCCCD) >> 35, exact for every 32-bit v
  parameter logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;
  parameter int unsigned DIV_SHIFT = 35;
  parameter int unsigned QUOT_W = 64 - DIV_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT,
    ST_SEP
  } fmt_state_e;

  typedef enum logic [1:0] {
    FLD_ID,
    FLD_PRICE,
    FLD_QTY
  } field_e;

  // result of one divide-by-ten pass
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [3:0]        digit;
  } div_res_t;

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== rtl/ofmt_div10.sv =====
// two-stage divide-by-ten unit giving quotient and decimal digit
module ofmt_div10 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        value_i,
  output ofmt_pkg::div_res_t res_o
);
  import ofmt_pkg::*;

  logic              s1_vld_q;
  logic [QUOT_W-1:0] s1_quot_q;
  logic [31:0]       s1_val_q;
  logic [63:0]       prod;
  logic [31:0]       times_ten;
  logic [31:0]       rem_full;
  logic              done_q;
  logic [QUOT_W-1:0] quot_q;
  logic [3:0]        digit_q;

  assign prod = {32'd0, value_i} * {32'd0, DIV_RECIP};

  // remainder by shift-add, no second multiplier
  assign times_ten = ({3'd0, s1_quot_q} << 3) + ({3'd0, s1_quot_q} << 1);
  assign rem_full  = s1_val_q - times_ten;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      done_q   <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_quot_q <= prod[63:DIV_SHIFT];
    s1_val_q  <= value_i;
    quot_q    <= s1_quot_q;
    digit_q   <= rem_full[3:0];
  end

  assign res_o.done  = done_q;
  assign res_o.quot  = quot_q;
  assign res_o.digit = digit_q;

endmodule

// ===== rtl/order_message_decimal_formatter_core.sv =====
// top level: sequencer, digit buffer and output register of the order message formatter
// the first byte goes out from the head state through the output register; bytes pause while a field converts
// each decimal digit passes through both stages of the shared divide-by-ten unit before the next one starts
// the order input is stalled until the terminating byte enters the output register; one order is formatted at a time
// reset clears the sequencer, the divider valid flags and the output valid flag
module order_message_decimal_formatter_core #(
  parameter int unsigned QTY_DIGITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] order_id_i,
  input  logic signed [31:0] order_price_i,
  input  logic [31:0]        order_quantity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         text_byte_o,
  output logic               is_last_o
);
  import ofmt_pkg::*;

  fmt_state_e state_q, state_d;
  field_e     field_q, field_d;

  logic [HEAD_IDX_W-1:0]  head_idx_q, head_idx_d;
  logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIGIT_IDX_W-1:0] rd_idx;
  logic [3:0]             digit_buf_q [DIGIT_MAX];

  // operands held for the fields still to print
  logic [31:0] price_q, price_d;
  logic [31:0] qty_q, qty_d;
  logic [31:0] val_q, val_d;
  logic        neg_q, neg_d;
  logic        pend_q, pend_d;

  logic        out_valid_q;
  logic [7:0]  text_byte_q;
  logic        is_last_q;

  logic        in_xfer;
  logic        slot_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        div_start;
  logic [31:0] div_val;
  logic        conv_last;
  div_res_t    div_res;

  ofmt_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (div_val),
    .res_o   (div_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // output register takes a new byte when empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  // digits are gathered least significant first and read back from the top
  assign rd_idx = DIGIT_IDX_W'(cnt_q - DIGIT_CNT_W'(1));

  // signed fields stop when the quotient runs out, the quantity after a fixed count
  assign conv_last = (field_q == FLD_QTY)
                   ? ((cnt_q + DIGIT_CNT_W'(1)) == DIGIT_CNT_W'(QTY_DIGITS))
                   : (div_res.quot == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        if (slot_free && head_idx_q == HEAD_IDX_W'(HEAD_LEN - 1)) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (div_res.done && conv_last) state_d = neg_q ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (slot_free) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (slot_free && cnt_q == DIGIT_CNT_W'(1)) state_d = ST_SEP;
      end
      ST_SEP: begin
        if (slot_free) state_d = (field_q == FLD_QTY) ? ST_IDLE : ST_CONV;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // byte selection and divider issue
  always_comb begin
    emit      = 1'b0;
    emit_byte = CH_NUL;
    emit_last = 1'b0;
    div_start = 1'b0;
    div_val   = val_q;
    case (state_q)
      ST_HEAD: begin
        emit      = slot_free;
        emit_byte = HEAD_TEXT[head_idx_q];
      end
      ST_CONV: begin
        if (!pend_q) begin
          div_start = 1'b1;
        end else if (div_res.done && !conv_last) begin
          // chain straight on with the fresh quotient
          div_start = 1'b1;
          div_val   = 32'(div_res.quot);
        end
      end
      ST_SIGN: begin
        emit      = slot_free;
        emit_byte = CH_MINUS;
      end
      ST_DIGIT: begin
        emit      = slot_free;
        emit_byte = CH_ZERO + 8'(digit_buf_q[rd_idx]);
      end
      ST_SEP: begin
        emit = slot_free;
        if (field_q == FLD_QTY) begin
          emit_byte = CH_NUL;
          emit_last = 1'b1;
        end else begin
          emit_byte = CH_SPACE;
        end
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    field_d    = field_q;
    head_idx_d = head_idx_q;
    cnt_d      = cnt_q;
    price_d    = price_q;
    qty_d      = qty_q;
    val_d      = val_q;
    neg_d      = neg_q;
    pend_d     = pend_q;

    if (in_xfer) begin
      field_d    = FLD_ID;
      head_idx_d = '0;
      cnt_d      = '0;
      price_d    = $unsigned(order_price_i);
      qty_d      = order_quantity_i;
      val_d      = magnitude($unsigned(order_id_i));
      neg_d      = order_id_i[31];
    end

    if (state_q == ST_HEAD && emit) head_idx_d = head_idx_q + HEAD_IDX_W'(1);

    if (div_start) begin
      pend_d = 1'b1;
    end else if (div_res.done) begin
      pend_d = 1'b0;
    end

    if (state_q == ST_CONV && div_res.done) cnt_d = cnt_q + DIGIT_CNT_W'(1);
    if (state_q == ST_DIGIT && emit) cnt_d = cnt_q - DIGIT_CNT_W'(1);

    // load the next field once its separator leaves
    if (state_q == ST_SEP && emit) begin
      case (field_q)
        FLD_ID: begin
          field_d = FLD_PRICE;
          val_d   = magnitude(price_q);
          neg_d   = price_q[31];
        end
        FLD_PRICE: begin
          field_d = FLD_QTY;
          val_d   = qty_q;
          neg_d   = 1'b0;
        end
        default: field_d = FLD_ID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      field_q     <= FLD_ID;
      head_idx_q  <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      field_q    <= field_d;
      head_idx_q <= head_idx_d;
      cnt_q      <= cnt_d;
      neg_q      <= neg_d;
      pend_q     <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
    val_q   <= val_d;
    if (emit) begin
      text_byte_q <= emit_byte;
      is_last_q   <= emit_last;
    end
    if (state_q == ST_CONV && div_res.done) begin
      digit_buf_q[cnt_q[DIGIT_IDX_W-1:0]] <= div_res.digit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_byte_o = text_byte_q;
  assign is_last_o   = is_last_q;

  // divider results only arrive while a field is being converted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_CONV)
    else $error("divider result outside conversion");

  // digit buffer never overruns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIGIT_CNT_W'(DIGIT_MAX))
    else $error("digit count beyond buffer");

  // every field prints at least one digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |-> cnt_q != '0)
    else $error("digit output with empty buffer");

  // the end marker only ever sits on the terminating byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> text_byte_o == CH_NUL)
    else $error("end marker on a non-terminating byte");

  // a new order starts with an empty digit buffer and no divide in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> cnt_q == '0 && !pend_q)
    else $error("order taken with conversion in flight");

endmodule

// ===== test/tb_order_message_decimal_formatter_core.sv =====
// self-checking testbench for the order message formatter: directed table, then random orders
module tb_order_message_decimal_formatter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ofmt_pkg::*;

  localparam int unsigned QTY_DIGITS = 4;
  localparam int N_DIRECTED = 15;
  localparam int N_RANDOM = 480;

  // one order as it goes over the input channel
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } order_t;

  // one character of a message as it comes out
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } msg_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic signed [31:0] order_id_i = '0;
  logic signed [31:0] order_price_i = '0;
  logic [31:0]       order_quantity_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        text_byte_o;
  logic              is_last_o;

  // characters still owed by the block, oldest first
  msg_byte_t expected_text [$];
  int        errors = 0;
  // set while neither side may idle
  logic      calm = 1'b0;

  // directed orders; a text typed in here is the message without its NUL,
  // an empty text means the formatter model below works it out
  order_t dir_orders [N_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'd0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'd9999},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1},
    '{32'd1,         32'd1,         32'd10000},
    '{32'd9,         32'hFFFF_FFF7, 32'd10},
    '{32'd10,        32'hFFFF_FFF6, 32'd99},
    '{32'd123456789, 32'hC521_974F, 32'd12345},
    '{32'd1000000000, 32'hC465_3600, 32'd100000},
    '{32'hFFFF_FFFE, 32'h0000_0000, 32'h8000_0000},
    '{32'h0000_0000, 32'd100,       32'd5},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
    '{32'h8000_0001, 32'h7FFF_FFFE, 32'd1000},
    '{32'd999999999, 32'hFA0A_1F01, 32'd999}
  };
  string dir_text [N_DIRECTED] = '{
    "NEW 0 0 0000",
    "NEW -2147483648 2147483647 9999",
    "NEW 2147483647 -2147483648 7295",
    "NEW -1 -1 0001",
    "NEW 1 1 0000",
    "NEW 9 -9 0010",
    "NEW 10 -10 0099",
    "", "", "", "", "", "", "", ""
  };

  order_message_decimal_formatter_core #(
    .QTY_DIGITS(QTY_DIGITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .order_id_i      (order_id_i),
    .order_price_i   (order_price_i),
    .order_quantity_i(order_quantity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .text_byte_o     (text_byte_o),
    .is_last_o       (is_last_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4ns;
    clk_i = 1'b1;
    #4ns;
  end

  // signed decimal, no leading zeros; the magnitude is taken modulo 2^32
  // so the most negative value needs no special handling
  function automatic void push_decimal(logic [31:0] v);
    logic [31:0] mag;
    logic [7:0]  digs [10];
    int          n;
    n = 0;
    if (v == 32'd0) begin
      expected_text.push_back('{CH_ZERO, 1'b0});
      return;
    end
    if (v[31]) begin
      expected_text.push_back('{CH_MINUS, 1'b0});
      mag = 32'd0 - v;
    end else begin
      mag = v;
    end
    while (mag != 32'd0) begin
      digs[n] = CH_ZERO + 8'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end
    while (n > 0) begin
      n--;
      expected_text.push_back('{digs[n], 1'b0});
    end
  endfunction

  // whole message for one order: head, id, price, padded quantity, NUL
  function automatic void format_order(order_t o);
    logic [7:0]  qd [QTY_DIGITS];
    logic [31:0] q;
    q = o.qty;
    expected_text.push_back('{8'h4E, 1'b0});
    expected_text.push_back('{8'h45, 1'b0});
    expected_text.push_back('{8'h57, 1'b0});
    expected_text.push_back('{CH_SPACE, 1'b0});
    push_decimal(o.id);
    expected_text.push_back('{CH_SPACE, 1'b0});
    push_decimal(o.price);
    expected_text.push_back('{CH_SPACE, 1'b0});
    // only the low decimal digits of a large quantity survive
    for (int i = QTY_DIGITS - 1; i >= 0; i--) begin
      qd[i] = CH_ZERO + 8'(q % 32'd10);
      q = q / 32'd10;
    end
    for (int i = 0; i < QTY_DIGITS; i++) expected_text.push_back('{qd[i], 1'b0});
    expected_text.push_back('{CH_NUL, 1'b1});
  endfunction

  // field values biased towards digit-count boundaries, signs and extremes
  function automatic logic [31:0] pick_field();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    k = $urandom_range(0, 9);
    repeat (k) p = p * 32'd10;
    case ($urandom_range(0, 7))
      0: return 32'($urandom_range(0, 20));
      1: return 32'd0 - 32'($urandom_range(1, 20));
      2: return p + 32'($urandom_range(0, 2)) - 32'd1;
      3: return 32'd0 - p - 32'($urandom_range(0, 1));
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // offer one order from a falling edge and hold it until the transfer;
  // valid is only lowered when a gap is taken, so it never drops between
  // back-to-back orders
  task automatic send_order(order_t o, string text);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 17) begin
      gap = $urandom_range(1, 100);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    order_id_i       = o.id;
    order_price_i    = o.price;
    order_quantity_i = o.qty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer taken: record what the message must read
    if (text.len() == 0) begin
      format_order(o);
    end else begin
      for (int i = 0; i < text.len(); i++) expected_text.push_back('{text[i], 1'b0});
      expected_text.push_back('{CH_NUL, 1'b1});
    end
  endtask

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(0, 99) < 17);
  end

  // compare every output transfer with the oldest owed character
  always @(posedge clk_i) begin : check_output
    msg_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        $error("unexpected transfer: text_byte %h is_last %b", text_byte_o, is_last_o);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (text_byte_o !== want.ch) begin
          $error("text_byte: expected %h, got %h", want.ch, text_byte_o);
          errors++;
        end
        if (is_last_o !== want.last) begin
          $error("is_last: expected %b, got %b", want.last, is_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    order_t o;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_order(dir_orders[i], dir_text[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      // a long stretch in the middle runs with neither side idling
      calm = (i >= 150) && (i < 230);
      o.id    = pick_field();
      o.price = pick_field();
      o.qty   = pick_field();
      send_order(o, "");
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // drain, then leave room for any stray transfer to show up
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("order_message_decimal_formatter_core: match");
    end else begin
      $display("order_message_decimal_formatter_core: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("order_message_decimal_formatter_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ofmt_pkg.sv
rtl/ofmt_div10.sv
rtl/order_message_decimal_formatter_core.sv
test/tb_order_message_decimal_formatter_core.sv
